FILE: hdl/vlg_pkg.sv
package vlg_pkg;

  // Fixed field widths of the stream beats and the register port
  localparam int COORD_W      = 5;
  localparam int FIELD_COST_W = 12;
  localparam int FIELD_ANC_W  = 24;
  localparam int SIZE_W       = 6;
  localparam int CFG_ADDR_W   = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  // Input beat: tuser carries the opcode, tdata the rest
  localparam int IN_USER_W = 2;
  localparam int IN_DATA_W = 80;
  localparam int OFF_X     = 0;
  localparam int OFF_Y     = OFF_X + COORD_W;
  localparam int OFF_Z     = OFF_Y + COORD_W;
  localparam int OFF_COST  = OFF_Z + COORD_W;
  localparam int OFF_ANC   = OFF_COST + FIELD_COST_W;
  localparam int OFF_NBR   = OFF_ANC + FIELD_ANC_W;
  localparam int OFF_NEW   = OFF_NBR + FIELD_COST_W;

  // Output beat
  localparam int OUT_DATA_W   = 40;
  localparam int OFF_OUT_COST = 0;
  localparam int OFF_OUT_ANC  = OFF_OUT_COST + FIELD_COST_W;
  localparam int OFF_GREW     = OFF_OUT_ANC + FIELD_ANC_W;
  localparam int OUT_PAD_W    = OUT_DATA_W - OFF_GREW - 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PASS  = 2'd2
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  // Status from the growth sequencer to the top level
  typedef struct packed {
    logic done;
    logic grew;
  } grow_stat_t;

endpackage

FILE: hdl/vlg_ram.sv
module vlg_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/vlg_grow.sv
module vlg_grow #(
  parameter int AW            = 5,
  parameter int COST_BITS     = 12,
  parameter int ANCESTOR_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [COST_BITS-1:0]               want,
  input  logic [COST_BITS-1:0]               fresh,
  input  logic [AW-1:0]                      last_x,
  input  logic [AW-1:0]                      last_y,
  input  logic [AW-1:0]                      last_z,
  output logic [3*AW-1:0]                    rd_addr,
  input  logic [ANCESTOR_BITS+COST_BITS-1:0] rd_data,
  output logic                               wr_en,
  output logic [3*AW-1:0]                    wr_addr,
  output logic [ANCESTOR_BITS+COST_BITS-1:0] wr_data,
  output vlg_pkg::grow_stat_t                stat
);
  import vlg_pkg::*;

  typedef enum logic [1:0] {G_IDLE, G_CENTER, G_SCAN, G_WRITE} gstate_t;

  // Probe order: center first, then the six neighbours in priority order
  typedef enum logic [2:0] {
    ST_CENTER = 3'd0,
    ST_XP     = 3'd1,
    ST_XM     = 3'd2,
    ST_YP     = 3'd3,
    ST_YM     = 3'd4,
    ST_ZP     = 3'd5,
    ST_ZM     = 3'd6
  } step_t;

  gstate_t                  state_r;
  step_t                    step_r;
  step_t                    rd_step;
  logic [AW-1:0]            px_r, py_r, pz_r;
  logic [AW-1:0]            last_x_r, last_y_r, last_z_r;
  logic [COST_BITS-1:0]     want_r, fresh_r;
  logic [ANCESTOR_BITS-1:0] anc_r;
  logic                     grew_r, done_r;
  logic [AW-1:0]            nx, ny, nz;
  logic [AW-1:0]            adv_x, adv_y, adv_z;
  logic                     adv_done;
  logic                     advance;
  logic [COST_BITS-1:0]     cur_cost;
  logic [ANCESTOR_BITS-1:0] cur_anc;

  assign cur_cost = rd_data[COST_BITS-1:0];
  assign cur_anc  = rd_data[ANCESTOR_BITS+COST_BITS-1:COST_BITS];

  // While scanning, the next probe is fetched speculatively under the current check
  assign rd_step = (state_r == G_SCAN) ? step_t'(step_r + 3'd1) : ST_CENTER;

  always_comb begin
    nx = px_r;
    ny = py_r;
    nz = pz_r;
    case (rd_step)
      ST_XP:   nx = px_r + AW'(1);
      ST_XM:   nx = px_r - AW'(1);
      ST_YP:   ny = py_r + AW'(1);
      ST_YM:   ny = py_r - AW'(1);
      ST_ZP:   nz = pz_r + AW'(1);
      ST_ZM:   nz = pz_r - AW'(1);
      default: ;
    endcase
  end

  assign rd_addr = {nx, ny, nz};

  // Raster step over the interior, z fastest
  always_comb begin
    adv_x    = px_r;
    adv_y    = py_r;
    adv_z    = pz_r + AW'(1);
    adv_done = 1'b0;
    if (pz_r == last_z_r) begin
      adv_z = AW'(1);
      adv_y = py_r + AW'(1);
      if (py_r == last_y_r) begin
        adv_y = AW'(1);
        adv_x = px_r + AW'(1);
        if (px_r == last_x_r) begin
          adv_done = 1'b1;
        end
      end
    end
  end

  // The current voxel is finished this cycle
  assign advance = (state_r == G_WRITE) ||
                   ((state_r == G_SCAN) && (step_r == ST_CENTER) && (cur_cost != '0)) ||
                   ((state_r == G_SCAN) && (step_r == ST_ZM) && (cur_cost != want_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      step_r  <= ST_CENTER;
      grew_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= advance && adv_done;
      case (state_r)
        G_IDLE: begin
          if (start) begin
            px_r     <= AW'(1);
            py_r     <= AW'(1);
            pz_r     <= AW'(1);
            last_x_r <= last_x;
            last_y_r <= last_y;
            last_z_r <= last_z;
            want_r   <= want;
            fresh_r  <= fresh;
            grew_r   <= 1'b0;
            state_r  <= G_CENTER;
          end
        end
        G_CENTER: begin
          step_r  <= ST_CENTER;
          state_r <= G_SCAN;
        end
        G_SCAN: begin
          if (step_r == ST_CENTER) begin
            if (cur_cost != '0) begin
              px_r    <= adv_x;
              py_r    <= adv_y;
              pz_r    <= adv_z;
              state_r <= adv_done ? G_IDLE : G_CENTER;
            end else begin
              step_r <= ST_XP;
            end
          end else if (cur_cost == want_r) begin
            anc_r   <= cur_anc;
            state_r <= G_WRITE;
          end else if (step_r == ST_ZM) begin
            px_r    <= adv_x;
            py_r    <= adv_y;
            pz_r    <= adv_z;
            state_r <= adv_done ? G_IDLE : G_CENTER;
          end else begin
            step_r <= step_t'(step_r + 3'd1);
          end
        end
        G_WRITE: begin
          grew_r  <= 1'b1;
          px_r    <= adv_x;
          py_r    <= adv_y;
          pz_r    <= adv_z;
          state_r <= adv_done ? G_IDLE : G_CENTER;
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign wr_en   = (state_r == G_WRITE);
  assign wr_addr = {px_r, py_r, pz_r};
  assign wr_data = {anc_r, fresh_r};

  assign stat.done = done_r;
  assign stat.grew = grew_r;

endmodule

FILE: hdl/voxel_layer_growth_core.sv
// Channel | Beat fields (low bit up)                                    | Direction
// in_     | tuser: opcode; tdata: coord_x, coord_y, coord_z, cost_in,   | into block
//         |   ancestor_in, neighbour_layer, new_layer                    |
// out_    | tdata: cost_out, ancestor_out, grew_any                      | out of block
// cfg_    | write enable, register index, size value                     | into block
//
// A write or unused opcode loads the output register as it is taken; a read goes through
// the registered memory read first. Growth pass: each interior voxel's center is read, and
// at zero cost its neighbours in turn (one read per probe on the single read port, one write
// when it grows). After reset a clearing pass writes all DEPTH words of the padded cube
// (32768 at DIM_MAX = 32) with in_tready low; register writes are taken meanwhile.
// in_tready is low during a read or a pass and while a result is held by a stalled out_.
module voxel_layer_growth_core #(
  parameter int DIM_MAX       = 32,
  parameter int COST_BITS     = 12,
  parameter int ANCESTOR_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // opcode
  input  logic [vlg_pkg::IN_USER_W-1:0]    in_tuser,
  // coord_x, coord_y, coord_z, cost_in, ancestor_in, neighbour_layer, new_layer, zero pad
  input  logic [vlg_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cost_out, ancestor_out, grew_any, zero pad
  output logic [vlg_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic [vlg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [vlg_pkg::SIZE_W-1:0]       cfg_wdata
);
  import vlg_pkg::*;

  localparam int AW     = $clog2(DIM_MAX);
  localparam int ADDR_W = 3 * AW;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int WORD_W = ANCESTOR_BITS + COST_BITS;
  localparam int CW     = (AW > COORD_W) ? AW : COORD_W;
  localparam int NW     = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
  localparam int CX     = (COST_BITS > FIELD_COST_W) ? COST_BITS : FIELD_COST_W;
  localparam int AX     = (ANCESTOR_BITS > FIELD_ANC_W) ? ANCESTOR_BITS : FIELD_ANC_W;

  typedef enum logic [1:0] {T_CLEAR, T_IDLE, T_READ, T_PASS} tstate_t;

  function automatic logic [COST_BITS-1:0] cost_from_field(input logic [FIELD_COST_W-1:0] v);
    logic signed [CX-1:0] ext;
    ext = CX'(signed'(v));
    return ext[COST_BITS-1:0];
  endfunction

  function automatic logic [FIELD_COST_W-1:0] cost_to_field(input logic [COST_BITS-1:0] c);
    logic [CX-1:0] ext;
    ext = CX'(c);
    return ext[FIELD_COST_W-1:0];
  endfunction

  function automatic logic [ANCESTOR_BITS-1:0] anc_from_field(
      input logic [FIELD_ANC_W-1:0] v);
    logic [AX-1:0] ext;
    ext = AX'(v);
    return ext[ANCESTOR_BITS-1:0];
  endfunction

  function automatic logic [FIELD_ANC_W-1:0] anc_to_field(input logic [ANCESTOR_BITS-1:0] a);
    logic [AX-1:0] ext;
    ext = AX'(a);
    return ext[FIELD_ANC_W-1:0];
  endfunction

  function automatic logic [AW-1:0] coord_idx(input logic [COORD_W-1:0] c);
    logic [CW-1:0] ext;
    ext = CW'(c);
    return ext[AW-1:0];
  endfunction

  function automatic logic [NW-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [NW-1:0] ext;
    ext = NW'(s);
    return (ext > NW'(DIM_MAX)) ? NW'(DIM_MAX) : ext;
  endfunction

  tstate_t                state_r;
  logic [ADDR_W-1:0]      clr_addr_r;
  logic [SIZE_W-1:0]      size_x_r, size_y_r, size_z_r;
  logic                   out_valid_r;
  logic [FIELD_COST_W-1:0] out_cost_r;
  logic [FIELD_ANC_W-1:0] out_anc_r;
  logic                   out_grew_r;
  logic                   rd_ok_r;

  logic [COORD_W-1:0]     f_x, f_y, f_z;
  logic [FIELD_COST_W-1:0] f_cost, f_nbr, f_new;
  logic [FIELD_ANC_W-1:0] f_anc;
  op_t                    op;
  logic                   acc;
  logic                   in_grid;
  logic [ADDR_W-1:0]      acc_addr;
  logic [NW-1:0]          n_x, n_y, n_z;
  logic [NW-1:0]          d_x, d_y, d_z;
  logic                   tiny_grid;
  logic                   out_load;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]      ram_wdata, ram_rdata;

  logic                   g_start;
  logic [ADDR_W-1:0]      g_raddr, g_waddr;
  logic                   g_we;
  logic [WORD_W-1:0]      g_wdata;
  grow_stat_t             g_stat;

  assign f_x    = in_tdata[OFF_X +: COORD_W];
  assign f_y    = in_tdata[OFF_Y +: COORD_W];
  assign f_z    = in_tdata[OFF_Z +: COORD_W];
  assign f_cost = in_tdata[OFF_COST +: FIELD_COST_W];
  assign f_anc  = in_tdata[OFF_ANC +: FIELD_ANC_W];
  assign f_nbr  = in_tdata[OFF_NBR +: FIELD_COST_W];
  assign f_new  = in_tdata[OFF_NEW +: FIELD_COST_W];
  assign op     = op_t'(in_tuser);

  assign in_tready = (state_r == T_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  assign in_grid  = (int'(f_x) < DIM_MAX) && (int'(f_y) < DIM_MAX) && (int'(f_z) < DIM_MAX);
  assign acc_addr = {coord_idx(f_x), coord_idx(f_y), coord_idx(f_z)};

  // Interior runs from 1 to size-2 along each axis
  assign n_x   = clamp_size(size_x_r);
  assign n_y   = clamp_size(size_y_r);
  assign n_z   = clamp_size(size_z_r);
  assign d_x   = n_x - NW'(2);
  assign d_y   = n_y - NW'(2);
  assign d_z   = n_z - NW'(2);
  assign tiny_grid = (n_x < NW'(3)) || (n_y < NW'(3)) || (n_z < NW'(3));

  assign g_start = acc && (op == OP_PASS) && !tiny_grid;

  // A result beat is loaded this cycle
  assign out_load = ((state_r == T_IDLE) && acc && (op != OP_READ) && !g_start) ||
                    (state_r == T_READ) ||
                    ((state_r == T_PASS) && g_stat.done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_SIZE_X: size_x_r <= cfg_wdata;
        REG_SIZE_Y: size_y_r <= cfg_wdata;
        REG_SIZE_Z: size_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (&clr_addr_r) begin
            state_r <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (acc) begin
            rd_ok_r <= in_grid;
            case (op)
              OP_READ: state_r <= T_READ;
              OP_PASS: begin
                if (tiny_grid) begin
                  out_cost_r  <= '0;
                  out_anc_r   <= '0;
                  out_grew_r  <= 1'b0;
                end else begin
                  state_r <= T_PASS;
                end
              end
              default: begin
                out_cost_r  <= '0;
                out_anc_r   <= '0;
                out_grew_r  <= 1'b0;
              end
            endcase
          end
        end
        T_READ: begin
          out_cost_r  <= rd_ok_r ? cost_to_field(ram_rdata[COST_BITS-1:0]) : '0;
          out_anc_r   <= rd_ok_r ? anc_to_field(ram_rdata[WORD_W-1:COST_BITS]) : '0;
          out_grew_r  <= 1'b0;
          state_r     <= T_IDLE;
        end
        T_PASS: begin
          if (g_stat.done) begin
            out_cost_r  <= '0;
            out_anc_r   <= '0;
            out_grew_r  <= g_stat.grew;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = acc_addr;
    ram_wdata = {anc_from_field(f_anc), cost_from_field(f_cost)};
    ram_raddr = acc_addr;
    case (state_r)
      T_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      T_IDLE:  ram_we = acc && (op == OP_WRITE) && in_grid;
      T_PASS: begin
        ram_we    = g_we;
        ram_waddr = g_waddr;
        ram_wdata = g_wdata;
        ram_raddr = g_raddr;
      end
      default: ;
    endcase
  end

  vlg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vlg_grow #(
    .AW            (AW),
    .COST_BITS     (COST_BITS),
    .ANCESTOR_BITS (ANCESTOR_BITS)
  ) u_grow (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (g_start),
    .want    (cost_from_field(f_nbr)),
    .fresh   (cost_from_field(f_new)),
    .last_x  (d_x[AW-1:0]),
    .last_y  (d_y[AW-1:0]),
    .last_z  (d_z[AW-1:0]),
    .rd_addr (g_raddr),
    .rd_data (ram_rdata),
    .wr_en   (g_we),
    .wr_addr (g_waddr),
    .wr_data (g_wdata),
    .stat    (g_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_grew_r, out_anc_r, out_cost_r};

endmodule

FILE: hdl/vlg_chk.sv
module vlg_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [vlg_pkg::IN_USER_W-1:0]    in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [vlg_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import vlg_pkg::*;

  logic acc;
  assign acc = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed or dropped");

  // Input is only taken when the result register is free or draining
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input taken while a result is stuck");

  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_tuser == OP_WRITE) |=> out_tvalid && (out_tdata == '0))
    else $error("write beat did not answer zero next cycle");

  a_read_ack: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_tuser == OP_READ) |=> !in_tready ##1 (out_tvalid && !out_tdata[OFF_GREW]))
    else $error("read beat did not answer two cycles later");

endmodule

bind voxel_layer_growth_core vlg_chk u_vlg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/voxel_layer_growth_core_test.sv
module voxel_layer_growth_core_test;
  import vlg_pkg::*;

  localparam int DIM = 32;
  localparam int STALL_LIMIT = 1_000_000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic [COORD_W-1:0]      z;
    logic [FIELD_COST_W-1:0] cost;
    logic [FIELD_ANC_W-1:0]  anc;
    logic [FIELD_COST_W-1:0] nbr;
    logic [FIELD_COST_W-1:0] fresh;
  } voxel_cmd_t;

  typedef struct packed {
    logic [FIELD_COST_W-1:0] cost;
    logic [FIELD_ANC_W-1:0]  anc;
    logic                    grew;
  } voxel_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [SIZE_W-1:0]     cfg_wdata = '0;

  // predicted grid, index {x, y, z}
  logic [FIELD_COST_W-1:0] voxel_cost [DIM*DIM*DIM];
  logic [FIELD_ANC_W-1:0]  voxel_anc  [DIM*DIM*DIM];
  logic [SIZE_W-1:0]       grid_size  [3];

  voxel_result_t pending_results [$];
  int error_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  voxel_layer_growth_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),   // opcode
    .in_tdata   (in_tdata),   // coord_x, coord_y, coord_z, cost_in, ancestor_in,
                              // neighbour_layer, new_layer
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // cost_out, ancestor_out, grew_any
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : scoreboard
    logic [1:0]              op;
    logic [COORD_W-1:0]      cx, cy, cz;
    logic [FIELD_COST_W-1:0] want, fresh;
    int                      nx, ny, nz, x, y, z, c, src;
    voxel_result_t           exp_r, got_r;

    if (rst_n && cfg_we) begin
      case (cfg_addr)
        REG_SIZE_X: grid_size[0] = cfg_wdata;
        REG_SIZE_Y: grid_size[1] = cfg_wdata;
        REG_SIZE_Z: grid_size[2] = cfg_wdata;
        default: ;
      endcase
    end

    if (rst_n && in_tvalid && in_tready) begin
      op    = in_tuser;
      cx    = in_tdata[OFF_X +: COORD_W];
      cy    = in_tdata[OFF_Y +: COORD_W];
      cz    = in_tdata[OFF_Z +: COORD_W];
      want  = in_tdata[OFF_NBR +: FIELD_COST_W];
      fresh = in_tdata[OFF_NEW +: FIELD_COST_W];
      exp_r = '0;
      case (op)
        OP_WRITE: begin
          voxel_cost[{cx, cy, cz}] = in_tdata[OFF_COST +: FIELD_COST_W];
          voxel_anc[{cx, cy, cz}]  = in_tdata[OFF_ANC +: FIELD_ANC_W];
        end
        OP_READ: begin
          exp_r.cost = voxel_cost[{cx, cy, cz}];
          exp_r.anc  = voxel_anc[{cx, cy, cz}];
        end
        OP_PASS: begin
          nx = (grid_size[0] > DIM) ? DIM : grid_size[0];
          ny = (grid_size[1] > DIM) ? DIM : grid_size[1];
          nz = (grid_size[2] > DIM) ? DIM : grid_size[2];
          // in place: voxels grown earlier in the sweep feed later ones
          for (x = 1; x < nx - 1; x++) begin
            for (y = 1; y < ny - 1; y++) begin
              for (z = 1; z < nz - 1; z++) begin
                c = (x * DIM + y) * DIM + z;
                if (voxel_cost[c] == '0) begin
                  src = -1;
                  if (voxel_cost[c + DIM*DIM] == want) src = c + DIM*DIM;
                  else if (voxel_cost[c - DIM*DIM] == want) src = c - DIM*DIM;
                  else if (voxel_cost[c + DIM] == want) src = c + DIM;
                  else if (voxel_cost[c - DIM] == want) src = c - DIM;
                  else if (voxel_cost[c + 1] == want) src = c + 1;
                  else if (voxel_cost[c - 1] == want) src = c - 1;
                  if (src >= 0) begin
                    exp_r.grew    = 1'b1;
                    voxel_cost[c] = fresh;
                    voxel_anc[c]  = voxel_anc[src];
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
      pending_results.insert(pending_results.size(), exp_r);
    end

    if (rst_n && out_tvalid && out_tready) begin
      got_r.cost = out_tdata[OFF_OUT_COST +: FIELD_COST_W];
      got_r.anc  = out_tdata[OFF_OUT_ANC +: FIELD_ANC_W];
      got_r.grew = out_tdata[OFF_GREW];
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_tdata[31:0], '0);
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.cost !== exp_r.cost)
          report_mismatch("cost_out", 32'(got_r.cost), 32'(exp_r.cost));
        if (got_r.anc !== exp_r.anc)
          report_mismatch("ancestor_out", 32'(got_r.anc), 32'(exp_r.anc));
        if (got_r.grew !== exp_r.grew)
          report_mismatch("grew_any", 32'(got_r.grew), 32'(exp_r.grew));
      end
    end

    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("voxel_layer_growth_core_test: errors");
    $finish;
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_cmd(input voxel_cmd_t c);
    logic [IN_DATA_W-1:0] beat;
    beat = '0;
    beat[OFF_X +: COORD_W]         = c.x;
    beat[OFF_Y +: COORD_W]         = c.y;
    beat[OFF_Z +: COORD_W]         = c.z;
    beat[OFF_COST +: FIELD_COST_W] = c.cost;
    beat[OFF_ANC +: FIELD_ANC_W]   = c.anc;
    beat[OFF_NBR +: FIELD_COST_W]  = c.nbr;
    beat[OFF_NEW +: FIELD_COST_W]  = c.fresh;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.op;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_voxel(input logic [COORD_W-1:0] x, y, z,
                             input logic [FIELD_COST_W-1:0] cost,
                             input logic [FIELD_ANC_W-1:0] anc);
    voxel_cmd_t c;
    c.op = OP_WRITE; c.x = x; c.y = y; c.z = z; c.cost = cost; c.anc = anc;
    c.nbr = 12'($urandom); c.fresh = 12'($urandom);
    send_cmd(c);
  endtask

  task automatic read_voxel(input logic [COORD_W-1:0] x, y, z);
    voxel_cmd_t c;
    c.op = OP_READ; c.x = x; c.y = y; c.z = z;
    c.cost = 12'($urandom); c.anc = 24'($urandom);
    c.nbr = 12'($urandom); c.fresh = 12'($urandom);
    send_cmd(c);
  endtask

  task automatic run_pass(input logic [FIELD_COST_W-1:0] nbr, fresh);
    voxel_cmd_t c;
    c.op = OP_PASS; c.x = 5'($urandom); c.y = 5'($urandom); c.z = 5'($urandom);
    c.cost = 12'($urandom); c.anc = 24'($urandom); c.nbr = nbr; c.fresh = fresh;
    send_cmd(c);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_sizes(input logic [SIZE_W-1:0] sx, sy, sz);
    wait_results_drained();
    cfg_write(REG_SIZE_X, sx);
    cfg_write(REG_SIZE_Y, sy);
    cfg_write(REG_SIZE_Z, sz);
  endtask

  task automatic test_reset_state();
    voxel_cmd_t c;
    // first beat waits out the clearing sweep
    read_voxel(5'd31, 5'd31, 5'd31);
    c = '1;
    c.op = OP_UNUSED;
    send_cmd(c);
  endtask

  task automatic test_voxel_access();
    voxel_cmd_t c;
    write_voxel(5'd0, 5'd0, 5'd0, 12'h7FF, 24'h000000);
    write_voxel(5'd31, 5'd31, 5'd31, 12'h800, 24'hFFFFFF);
    read_voxel(5'd31, 5'd31, 5'd31);
    read_voxel(5'd0, 5'd0, 5'd0);
    // unused opcode must leave the grid alone
    c = '1;
    c.op = OP_UNUSED; c.x = 5'd0; c.y = 5'd0; c.z = 5'd0;
    send_cmd(c);
    read_voxel(5'd0, 5'd0, 5'd0);
  endtask

  task automatic test_full_grid_pass();
    // sizes still at reset value; the two seeds next to (10,10,10) check probe order
    write_voxel(5'd16, 5'd16, 5'd16, 12'd5, 24'h123456);
    write_voxel(5'd11, 5'd10, 5'd10, 12'd5, 24'hA5A5A5);
    write_voxel(5'd10, 5'd11, 5'd10, 12'd5, 24'h5A5A5A);
    run_pass(12'd5, 12'd6);
    read_voxel(5'd10, 5'd10, 5'd10);
    read_voxel(5'd17, 5'd16, 5'd16);
  endtask

  task automatic test_small_grids();
    set_sizes(6'd3, 6'd3, 6'd3);
    write_voxel(5'd2, 5'd1, 5'd1, 12'd7, 24'hC0FFEE);
    run_pass(12'd7, 12'd0);    // grows to zero cost: flagged but still zero
    run_pass(12'd7, 12'hFFF);
    read_voxel(5'd1, 5'd1, 5'd1);
    set_sizes(6'd0, 6'd63, 6'd2);
    run_pass(12'd0, 12'd1);
    // x clamps to the grid; the unused index must change nothing
    set_sizes(6'd63, 6'd3, 6'd8);
    cfg_write(REG_UNUSED, 6'h15);
    write_voxel(5'd5, 5'd1, 5'd0, 12'd9, 24'h0F0F0F);
    run_pass(12'd9, 12'd9);    // same layer cascades within the sweep
    read_voxel(5'd5, 5'd1, 5'd6);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int rounds);
    int sz [3];
    int hi [3];
    int k;
    int pick;
    logic [FIELD_COST_W-1:0] layer;
    logic [FIELD_COST_W-1:0] cost;
    voxel_cmd_t c;
    wait_results_drained();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (rounds) begin
      for (k = 0; k < 3; k++) sz[k] = $urandom_range(6, 3);
      if ($urandom_range(3) == 0) sz[$urandom_range(2)] = $urandom_range(63);
      set_sizes(6'(sz[0]), 6'(sz[1]), 6'(sz[2]));
      for (k = 0; k < 3; k++) begin
        hi[k] = (sz[k] > DIM) ? DIM - 1 : ((sz[k] == 0) ? 0 : sz[k] - 1);
      end
      layer = $urandom_range(1) ? 12'($urandom) : 12'($urandom_range(8, 1));
      repeat (40) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          case ($urandom_range(3))
            0: cost = '0;
            1: cost = layer;
            2: cost = layer + 1'b1;
            default: cost = 12'($urandom);
          endcase
          write_voxel(5'($urandom_range(hi[0])), 5'($urandom_range(hi[1])),
                      5'($urandom_range(hi[2])), cost, 24'($urandom));
        end else if (pick < 60) begin
          read_voxel(5'($urandom_range(hi[0])), 5'($urandom_range(hi[1])),
                     5'($urandom_range(hi[2])));
        end else if (pick < 75) begin
          run_pass(($urandom_range(4) == 0) ? 12'($urandom) : layer,
                   ($urandom_range(5) == 0) ? 12'd0 : layer + 1'b1);
          if ($urandom_range(1)) layer = layer + 1'b1;
        end else begin
          c.op = 2'($urandom_range(3));
          c.x = 5'($urandom); c.y = 5'($urandom); c.z = 5'($urandom);
          c.cost = 12'($urandom); c.anc = 24'($urandom);
          c.nbr = 12'($urandom); c.fresh = 12'($urandom);
          send_cmd(c);
        end
      end
    end
  endtask

  initial begin
    foreach (voxel_cost[i]) begin
      voxel_cost[i] = '0;
      voxel_anc[i]  = '0;
    end
    foreach (grid_size[i]) grid_size[i] = SIZE_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 27;
    recv_idle_pct = 66;
    test_reset_state();
    test_voxel_access();
    test_full_grid_pass();
    test_small_grids();
    test_random_traffic(27, 66, 8);
    test_random_traffic(66, 27, 8);
    test_random_traffic(0, 0, 8);
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", pending_results.size(), 0);
    end
    if (error_count == 0) begin
      $display("voxel_layer_growth_core_test: clean");
    end else begin
      $display("voxel_layer_growth_core_test: errors");
    end
    $finish;
  end

endmodule
